/* src/iprd_pkg.sv */
// ----------------------------------------------------------------------------
// iprd_pkg: shared types and constants for the image pair RMS difference block
// Register indexes, run modes, queue entry and result payload types.
// ----------------------------------------------------------------------------
package iprd_pkg;

  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned COL_W    = 13;
  localparam int unsigned ROW_W    = 14;
  localparam int unsigned WIDTH_W  = 14;
  // pixels past 2^PIX_LOG2 in one frame are not added to the sums
  localparam int unsigned PIX_LOG2 = 26;
  localparam int unsigned SUM_W    = 2 * SMP_W + PIX_LOG2;
  localparam int unsigned CNT_W    = PIX_LOG2 + 1;
  localparam int unsigned PIX_W    = 34;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [WIDTH_W-1:0] MaxWidth = 14'd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH = 2'd0,
    REG_CHANS = 2'd1,
    REG_MODE  = 2'd2,
    REG_LIMIT = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_RMS  = 2'd0,
    MODE_MAX  = 2'd1,
    MODE_CMP  = 2'd2,
    MODE_NONE = 2'd3
  } run_mode_e;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_DIV,
    BK_SQRT,
    BK_OUT
  } back_state_e;

  // one pixel as classified by the front part
  typedef struct packed {
    logic [NUM_CH-1:0][SMP_W-1:0] diff;
    logic [NUM_CH-1:0]            used;
    logic                         over;
    logic                         last;
    logic [COL_W-1:0]             col;
    logic [ROW_W-1:0]             row;
    logic [1:0]                   mode;
  } pix_t;

  typedef struct packed {
    logic [NUM_CH-1:0][SMP_W-1:0] rms;
    logic                         max_found;
    logic [COL_W-1:0]             max_col;
    logic [ROW_W-1:0]             max_row;
    logic                         images_match;
    logic [COL_W-1:0]             miss_col;
    logic [ROW_W-1:0]             miss_row;
  } res_t;

  typedef struct packed {
    logic [NUM_CH-1:0][SMP_W-1:0] a;
    logic [NUM_CH-1:0][SMP_W-1:0] b;
    logic                         last_pixel;
  } pair_t;

endpackage

/* src/iprd_if.sv */
// ----------------------------------------------------------------------------
// iprd_if: valid/ready channel carrying one payload
// Source drives valid and data, sink drives ready.
// ----------------------------------------------------------------------------
interface iprd_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/iprd_front.sv */
// ----------------------------------------------------------------------------
// iprd_front: pixel classifier
// Forms channel differences, the over-limit flag and the raster position.
// ----------------------------------------------------------------------------
module iprd_front import iprd_pkg::*; #(
  parameter int unsigned Channels   = 4,
  parameter int unsigned SampleBits = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pair_t             in_data_i,
  input  logic [WIDTH_W-1:0] width_i,
  input  logic [2:0]        chans_i,
  input  logic [1:0]        mode_i,
  input  logic [SMP_W-1:0]  limit_i,
  output logic              pix_valid_o,
  input  logic              pix_ready_i,
  output pix_t              pix_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [2:0]       nch;
  logic [WIDTH_W-1:0] wid;
  logic             take;

  assign in_ready_o  = pix_ready_i;
  assign pix_valid_o = in_valid_i;
  assign take        = in_valid_i && pix_ready_i;

  always_comb begin
    nch = chans_i;
    if (nch == 3'd0) nch = 3'd1;
    if (nch > 3'(Channels)) nch = 3'(Channels);
    wid = width_i;
    if (wid == '0) wid = 14'd1;
    if (wid > MaxWidth) wid = MaxWidth;
  end

  always_comb begin
    logic [SMP_W-1:0] a, b;
    pix_o = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      a = in_data_i.a[c] & SMP_W'((17'd1 << SampleBits) - 17'd1);
      b = in_data_i.b[c] & SMP_W'((17'd1 << SampleBits) - 17'd1);
      pix_o.used[c] = (3'(c) < nch);
      pix_o.diff[c] = pix_o.used[c] ? ((a >= b) ? a - b : b - a) : '0;
      if (pix_o.used[c] && pix_o.diff[c] > limit_i) pix_o.over = 1'b1;
    end
    pix_o.last = in_data_i.last_pixel;
    pix_o.col  = col_q;
    pix_o.row  = row_q;
    pix_o.mode = mode_i;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take) begin
      if (in_data_i.last_pixel) begin
        col_d = '0;
        row_d = '0;
      end else if ({1'b0, col_q} + 14'd1 >= wid) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* src/iprd_fifo.sv */
// ----------------------------------------------------------------------------
// iprd_fifo: short queue between classifier and accumulator
// Two-entry register queue, full-throughput valid/ready.
// ----------------------------------------------------------------------------
module iprd_fifo import iprd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  pix_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output pix_t rd_data_o
);

  pix_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  occupancy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue occupancy out of range");
  no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");

endmodule

/* src/iprd_back.sv */
// ----------------------------------------------------------------------------
// iprd_back: accumulator and end-of-frame divide / square root
// While running, squares one pixel per cycle into per-channel sums, then per channel
// runs a bit-serial divide (sum/count) and a two-bit-per-step integer square root.
// ----------------------------------------------------------------------------
module iprd_back import iprd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pix_valid_i,
  output logic      pix_ready_o,
  input  pix_t      pix_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output res_t      res_o
);

  localparam int unsigned DivStepW = 6;
  localparam int unsigned SqStepW  = 5;

  back_state_e state_q, state_d;

  logic [NUM_CH-1:0][SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PIX_W-1:0]  best_q;
  logic [COL_W-1:0]  best_col_q, miss_col_q;
  logic [ROW_W-1:0]  best_row_q, miss_row_q;
  logic              best_vld_q, miss_q;
  logic [1:0]        mode_q;
  logic [1:0]        ch_q;
  logic [DivStepW-1:0] step_q;
  logic [SUM_W-1:0]  quo_q, rem_q;
  logic [SUM_W-1:0]  sq_v_q, sq_r_q;
  logic [SqStepW-1:0] sstep_q;
  logic [NUM_CH-1:0][SMP_W-1:0] rms_q;
  logic [NUM_CH-1:0] used_q;

  logic              take, accum, done_ch;
  logic [PIX_W-1:0]  pix_sum;
  logic [NUM_CH-1:0][2*SMP_W-1:0] sq;

  assign pix_ready_o = (state_q == BK_RUN);
  assign take  = pix_valid_i && pix_ready_o;
  assign accum = (cnt_q < CNT_W'(64'd1 << PIX_LOG2));

  always_comb begin
    pix_sum = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      sq[c] = pix_i.diff[c] * pix_i.diff[c];
      pix_sum = pix_sum + PIX_W'(sq[c]);
    end
  end

  // divide step: restoring, one quotient bit per cycle
  logic [SUM_W:0]   rem_sh;
  logic             ge;
  always_comb begin
    rem_sh = {rem_q, quo_q[SUM_W-1]};
    ge = rem_sh >= (SUM_W+1)'(cnt_q);
  end

  // sqrt step: two radicand bits per cycle
  logic [SUM_W+1:0] trial;
  logic [SUM_W+1:0] rad;
  logic             sq_ge;
  always_comb begin
    rad   = {sq_r_q, sq_v_q[SUM_W-1 -: 2]};
    trial = {SUM_W'(rms_q[ch_q]), 2'b01};
    sq_ge = (rad >= trial);
  end

  assign done_ch = (sstep_q == SqStepW'(SUM_W/2 - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_RUN:  if (take && pix_i.last) state_d = BK_DIV;
      BK_DIV:  if (step_q == DivStepW'(SUM_W-1)) state_d = BK_SQRT;
      BK_SQRT: if (done_ch) state_d = (ch_q == 2'(NUM_CH-1)) ? BK_OUT : BK_DIV;
      BK_OUT:  if (res_ready_i) state_d = BK_RUN;
      default: state_d = BK_RUN;
    endcase
  end

  // findings are held until the result handshake, so the payload reads them directly
  always_comb begin
    res_valid_o = (state_q == BK_OUT);
    res_o = '0;
    res_o.rms = rms_q;
    if ((mode_q == MODE_MAX) && best_vld_q) begin
      res_o.max_found = 1'b1;
      res_o.max_col   = best_col_q;
      res_o.max_row   = best_row_q;
    end
    if (mode_q == MODE_CMP) begin
      res_o.images_match = !miss_q;
      if (miss_q) begin
        res_o.miss_col = miss_col_q;
        res_o.miss_row = miss_row_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_RUN;
      sum_q <= '0; cnt_q <= '0; best_q <= '0;
      best_col_q <= '0; best_row_q <= '0; best_vld_q <= 1'b0;
      miss_q <= 1'b0; miss_col_q <= '0; miss_row_q <= '0;
      mode_q <= '0; ch_q <= '0; step_q <= '0; sstep_q <= '0;
      quo_q <= '0; rem_q <= '0; sq_v_q <= '0; sq_r_q <= '0;
      rms_q <= '0; used_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        BK_RUN: begin
          if (take) begin
            if (accum) begin
              for (int c = 0; c < NUM_CH; c++)
                sum_q[c] <= sum_q[c] + SUM_W'(sq[c]);
              cnt_q <= cnt_q + 1'b1;
            end
            if (pix_i.mode == MODE_MAX && pix_sum > best_q) begin
              best_q <= pix_sum; best_col_q <= pix_i.col;
              best_row_q <= pix_i.row; best_vld_q <= 1'b1;
            end
            if (pix_i.mode == MODE_CMP && pix_i.over && !miss_q) begin
              miss_q <= 1'b1; miss_col_q <= pix_i.col; miss_row_q <= pix_i.row;
            end
            if (pix_i.last) begin
              mode_q <= pix_i.mode;
              used_q <= pix_i.used;
              ch_q <= '0; step_q <= '0;
              quo_q <= (accum ? sum_q[0] + SUM_W'(sq[0]) : sum_q[0]);
              rem_q <= '0;
            end
          end
        end
        BK_DIV: begin
          step_q <= step_q + 1'b1;
          rem_q  <= ge ? SUM_W'(rem_sh - (SUM_W+1)'(cnt_q)) : rem_sh[SUM_W-1:0];
          quo_q  <= {quo_q[SUM_W-2:0], ge};
          if (step_q == DivStepW'(SUM_W-1)) begin
            sq_v_q <= {quo_q[SUM_W-2:0], ge};
            sq_r_q <= '0; sstep_q <= '0;
            rms_q[ch_q] <= '0;
          end
        end
        BK_SQRT: begin
          sstep_q <= sstep_q + 1'b1;
          sq_v_q <= {sq_v_q[SUM_W-3:0], 2'b00};
          sq_r_q <= sq_ge ? SUM_W'(rad - trial) : SUM_W'(rad);
          if (done_ch && (!used_q[ch_q] || cnt_q == '0)) begin
            rms_q[ch_q] <= '0;
          end else begin
            rms_q[ch_q] <= {rms_q[ch_q][SMP_W-2:0], sq_ge};
          end
          if (done_ch) begin
            ch_q <= ch_q + 1'b1;
            step_q <= '0; rem_q <= '0;
            quo_q <= sum_q[2'(ch_q + 1'b1)];
          end
        end
        BK_OUT: begin
          if (res_ready_i) begin
            sum_q <= '0; cnt_q <= '0; best_q <= '0;
            best_col_q <= '0; best_row_q <= '0; best_vld_q <= 1'b0;
            miss_q <= 1'b0; miss_col_q <= '0; miss_row_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != BK_RUN |-> !take) else $error("pixel taken during finish");
  cleared_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_OUT && res_ready_i |=> cnt_q == '0 && !miss_q)
    else $error("frame state not cleared");
  div_to_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV && step_q == DivStepW'(SUM_W-1) |=> state_q == BK_SQRT)
    else $error("divide did not hand off");

endmodule

/* src/iprd_outreg.sv */
// ----------------------------------------------------------------------------
// iprd_outreg: registered result stage
// Latches the back part's result so its finish logic can release early.
// ----------------------------------------------------------------------------
module iprd_outreg import iprd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);
  logic vld_q;
  res_t dat_q;

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_data_o  = dat_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) dat_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (in_ready_o) vld_q <= in_valid_i;
  end
endmodule

/* src/image_pair_rms_difference.sv */
// ----------------------------------------------------------------------------
// image_pair_rms_difference: per-channel RMS of two images' difference
// Accumulates squared differences, finds max pixel or first over-limit pixel.
// ----------------------------------------------------------------------------
// channel  dir  payload                         handshake
// pix_in   in   a/b samples x4, last_pixel      valid/ready
// res_out  out  rms x4, max and miss findings   valid/ready
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i write enable
//
// One pixel per cycle while a frame streams; the accumulator squares and adds
// in the same cycle that it takes a pixel. On the last pixel the back part runs
// per channel a serial divide and a square root and then offers the result,
// during which the back takes no pixel; the two-entry queue fills, then input
// stalls. The result reaches res_out through the output register. Reset clears
// all frame state.
module image_pair_rms_difference import iprd_pkg::*; #(
  parameter int unsigned CHANNELS        = 4,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  iprd_if.sink                 pix_in,
  iprd_if.source               res_out,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  logic [WIDTH_W-1:0] width_q;
  logic [2:0]         chans_q;
  logic [1:0]         mode_q;
  logic [SMP_W-1:0]   limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 14'd1;
      chans_q <= 3'd4;
      mode_q  <= MODE_RMS;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WIDTH: width_q <= cfg_data_i[WIDTH_W-1:0];
        REG_CHANS: chans_q <= cfg_data_i[2:0];
        REG_MODE:  mode_q  <= cfg_data_i[1:0];
        REG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic f_valid, f_ready, q_valid, q_ready, r_valid, r_ready;
  pix_t f_pix, q_pix;
  res_t r_res;

  iprd_front #(.Channels(CHANNELS), .SampleBits(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(pix_in.valid), .in_ready_o(pix_in.ready), .in_data_i(pix_in.data),
    .width_i(width_q), .chans_i(chans_q), .mode_i(mode_q), .limit_i(limit_q),
    .pix_valid_o(f_valid), .pix_ready_i(f_ready), .pix_o(f_pix)
  );

  iprd_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_pix),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_pix)
  );

  iprd_back u_back (
    .clk_i, .rst_ni,
    .pix_valid_i(q_valid), .pix_ready_o(q_ready), .pix_i(q_pix),
    .res_valid_o(r_valid), .res_ready_i(r_ready), .res_o(r_res)
  );

  iprd_outreg u_out (
    .clk_i, .rst_ni,
    .in_valid_i(r_valid), .in_ready_o(r_ready), .in_data_i(r_res),
    .out_valid_o(res_out.valid), .out_ready_i(res_out.ready), .out_data_o(res_out.data)
  );

endmodule
